// ===== src/bhst_pkg.sv =====
package bhst_pkg;

    localparam int NUM_BUCKETS      = 512;
    localparam int SLOTS_PER_BUCKET = 10;
    localparam int CHAR_OFFSET      = 32;
    localparam int NUM_CHARS        = 4;

    localparam int CHAR_W   = 7;
    localparam int REC_W    = 16;
    localparam int BKT_W    = 9;
    localparam int STAT_W   = 2;
    localparam int DEPTH    = NUM_BUCKETS * SLOTS_PER_BUCKET;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int SLOT_W   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int HSUM_W   = 11;

    localparam logic              OP_INSERT    = 1'b0;
    localparam logic              OP_SEARCH    = 1'b1;
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [CHAR_W-1:0] key_char0;
        logic [CHAR_W-1:0] key_char1;
        logic [CHAR_W-1:0] key_char2;
        logic [CHAR_W-1:0] key_char3;
    } t_req;

    typedef struct packed {
        logic [REC_W-1:0]  record_number;
        logic [BKT_W-1:0]  bucket;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_res;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_FLUSH
    } t_state;

    function automatic logic [BKT_W-1:0] hash_key(input t_req req);
        logic [HSUM_W-1:0] sum;
        sum = HSUM_W'(req.key_char0) + HSUM_W'(req.key_char1)
            + HSUM_W'(req.key_char2) + HSUM_W'(req.key_char3);
        if (sum < HSUM_W'(NUM_CHARS * CHAR_OFFSET)) begin
            sum = '0;
        end else begin
            sum = sum - HSUM_W'(NUM_CHARS * CHAR_OFFSET);
            if (sum >= HSUM_W'(NUM_BUCKETS)) begin
                sum = sum - HSUM_W'(NUM_BUCKETS);
            end
        end
        return sum[BKT_W-1:0];
    endfunction

endpackage

// ===== src/bucketed_hash_slot_table_unit.sv =====
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             i_req  (t_req)
// result    out        o_strobe, one cycle only  o_res  (t_res)
//
// An insert or a search takes the start cycle, then probes its bucket's slots
// in turn; a search adds a flush of the final hit when the bucket is full.
// One slot a cycle: the slot memory's single read port sets the pace.
// After reset the slot memory is cleared, one entry a cycle, all 5120 entries,
// with busy high.
// Results cannot be stalled; each is shown for exactly one cycle.
module bucketed_hash_slot_table_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  bhst_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output bhst_pkg::t_res o_res
);
    import bhst_pkg::*;

    logic [REC_W-1:0] r_mem [DEPTH];

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic               r_op, n_op;
    logic [BKT_W-1:0]   r_bkt, n_bkt;
    logic [REC_W-1:0]   r_cnt, n_cnt;
    logic [REC_W-1:0]   r_pend, n_pend;
    logic               r_pend_v, n_pend_v;
    logic               r_strobe, n_strobe;
    t_res               r_res, n_res;
    logic [REC_W-1:0]   r_rdata;

    logic               wr_en;
    logic [REC_W-1:0]   wr_data;
    logic [BKT_W-1:0]   hash;
    logic               last_slot;
    logic [REC_W-1:0]   cnt_inc;

    assign hash      = hash_key(i_req);
    assign last_slot = (r_slot == SLOT_W'(SLOTS_PER_BUCKET - 1));
    assign cnt_inc   = (r_cnt != '1) ? r_cnt + REC_W'(1) : r_cnt;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_addr] <= wr_data;
        end
        r_rdata <= r_mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_cnt    <= REC_W'(1);
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_cnt    <= n_cnt;
            r_pend_v <= n_pend_v;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_op   <= n_op;
        r_bkt  <= n_bkt;
        r_pend <= n_pend;
        r_res  <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_slot   = r_slot;
        n_op     = r_op;
        n_bkt    = r_bkt;
        n_cnt    = r_cnt;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_strobe = 1'b0;
        n_res    = r_res;
        wr_en    = 1'b0;
        wr_data  = '0;

        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (r_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state  = S_PROBE;
                    n_op     = i_req.opcode;
                    n_bkt    = hash;
                    n_slot   = '0;
                    n_pend_v = 1'b0;
                    n_addr   = ADDR_W'(hash) * ADDR_W'(SLOTS_PER_BUCKET);
                end
            end
            S_PROBE: begin
                if (!last_slot) begin
                    n_addr = r_addr + ADDR_W'(1);
                    n_slot = r_slot + SLOT_W'(1);
                end
                n_res.bucket = r_bkt;
                if (r_op == OP_INSERT) begin
                    if (r_rdata == '0) begin
                        wr_en   = 1'b1;
                        wr_data = r_cnt;
                        n_strobe = 1'b1;
                        n_res.record_number = r_cnt;
                        n_res.status = ST_OK;
                        n_res.last   = 1'b1;
                        n_cnt   = cnt_inc;
                        n_state = S_IDLE;
                    end else if (last_slot) begin
                        n_strobe = 1'b1;
                        n_res.record_number = '0;
                        n_res.status = ST_FULL;
                        n_res.last   = 1'b1;
                        n_cnt   = cnt_inc;
                        n_state = S_IDLE;
                    end
                end else begin
                    if (r_rdata == '0) begin
                        n_strobe = 1'b1;
                        n_res.last = 1'b1;
                        if (r_pend_v) begin
                            n_res.record_number = r_pend;
                            n_res.status = ST_OK;
                        end else begin
                            n_res.record_number = '0;
                            n_res.status = ST_NOT_FOUND;
                        end
                        n_pend_v = 1'b0;
                        n_state  = S_IDLE;
                    end else begin
                        // hold one hit back until we know whether it is the last
                        if (r_pend_v) begin
                            n_strobe = 1'b1;
                            n_res.record_number = r_pend;
                            n_res.status = ST_OK;
                            n_res.last   = 1'b0;
                        end
                        n_pend   = r_rdata;
                        n_pend_v = 1'b1;
                        if (last_slot) begin
                            n_state = S_FLUSH;
                        end
                    end
                end
            end
            S_FLUSH: begin
                n_strobe = 1'b1;
                n_res.record_number = r_pend;
                n_res.bucket = r_bkt;
                n_res.status = ST_OK;
                n_res.last   = 1'b1;
                n_pend_v = 1'b0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_no_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result in the cycle after a request was taken");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.last) |=> o_strobe)
        else $error("non-final result not followed by another result");

    a_full_has_no_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.status == ST_FULL) |-> (o_res.record_number == '0 && o_res.last))
        else $error("bucket-full result carries a record number");

    a_not_found_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.status == ST_NOT_FOUND) |-> o_res.last)
        else $error("not-found result is not final");

    a_counter_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != '0)
        else $error("record counter reached zero");

endmodule
